/* design/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants, codes and types of the positional array table.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int WORD_W = 32;
  localparam int OP_W   = 4;
  localparam int POS_W  = 8;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 3;
  localparam int OIDX_W = 4;
  localparam int OCNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register word index taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_INS_END   = 4'd0,
    OP_INS_START = 4'd1,
    OP_INS_POS   = 4'd2,
    OP_DEL_END   = 4'd3,
    OP_DEL_START = 4'd4,
    OP_DEL_POS   = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_UPDATE    = 4'd7,
    OP_DUMP      = 4'd8
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHUP,
    S_SHUP_LAST,
    S_INS_WR,
    S_SHDN,
    S_SHDN_LAST,
    S_SRCH,
    S_DUMP_RD,
    S_DUMP_EM,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } request_t;

  typedef struct packed {
    status_t                  status;
    logic [OIDX_W-1:0]        index;
    logic signed [WORD_W-1:0] data;
    logic [OCNT_W-1:0]        count;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         addr;
    logic signed [WORD_W-1:0] data;
  } ram_wr_t;

endpackage

/* design/pat_ram.sv */
// ----------------------------------------------------------------------------
// pat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pat_ctrl.sv */
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer of the table: decodes one request, walks the entry memory for
// shifts, searches and dumps, and hands results to the output stage.
// ----------------------------------------------------------------------------
module pat_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  pat_pkg::request_t                req,
  input  logic [pat_pkg::CAP_W-1:0]        cap_limit,
  input  logic                             out_free,
  output logic                             res_valid,
  output pat_pkg::result_t                 res,
  output pat_pkg::ram_wr_t                 ram_wr,
  output logic [pat_pkg::IDX_W-1:0]        ram_raddr,
  input  logic signed [pat_pkg::WORD_W-1:0] ram_rdata
);

  pat_pkg::state_t                  state, state_next;
  logic [pat_pkg::OP_W-1:0]         op;
  logic signed [pat_pkg::WORD_W-1:0] val;
  logic [pat_pkg::POS_W-1:0]        pos;
  logic [pat_pkg::CNT_W-1:0]        count;
  logic [pat_pkg::IDX_W-1:0]        p;
  logic [pat_pkg::IDX_W-1:0]        rptr;
  logic [pat_pkg::IDX_W-1:0]        wptr;
  logic                             wpend;
  logic [pat_pkg::IDX_W-1:0]        cptr;
  logic                             cvalid;
  pat_pkg::status_t                 st;
  logic [pat_pkg::IDX_W-1:0]        idx;

  logic [pat_pkg::POS_W-1:0] cnt8, cap8, dep8, lim8, ins_pos8, del_pos8;
  logic [pat_pkg::IDX_W-1:0] last_idx;
  logic                      full, ins_bad, found, cmp_last;

  assign cnt8     = pat_pkg::POS_W'(count);
  assign cap8     = pat_pkg::POS_W'(cap_limit);
  assign dep8     = pat_pkg::POS_W'(pat_pkg::DEPTH);
  assign lim8     = (cap8 > dep8) ? dep8 : cap8;
  assign ins_pos8 = (op == pat_pkg::OP_INS_END)   ? cnt8 :
                    (op == pat_pkg::OP_INS_START) ? '0 : pos;
  assign del_pos8 = (op == pat_pkg::OP_DEL_START) ? '0 : pos;
  assign full     = cnt8 >= lim8;
  assign ins_bad  = ins_pos8 > cnt8;
  assign last_idx = pat_pkg::IDX_W'(count - 1'b1);
  assign found    = cvalid && (ram_rdata == val);
  assign cmp_last = cptr == last_idx;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pat_pkg::S_IDLE: begin
        if (req_valid) state_next = pat_pkg::S_DECODE;
      end
      pat_pkg::S_DECODE: begin
        unique case (op) inside
          pat_pkg::OP_INS_END, pat_pkg::OP_INS_START, pat_pkg::OP_INS_POS: begin
            if (full || ins_bad)         state_next = pat_pkg::S_RESP;
            else if (ins_pos8 == cnt8)   state_next = pat_pkg::S_INS_WR;
            else                         state_next = pat_pkg::S_SHUP;
          end
          pat_pkg::OP_DEL_START, pat_pkg::OP_DEL_POS: begin
            if (del_pos8 >= cnt8)                state_next = pat_pkg::S_RESP;
            else if (del_pos8 == cnt8 - 1'b1)    state_next = pat_pkg::S_RESP;
            else                                 state_next = pat_pkg::S_SHDN;
          end
          pat_pkg::OP_DEL_END, pat_pkg::OP_UPDATE: state_next = pat_pkg::S_RESP;
          pat_pkg::OP_SEARCH: begin
            state_next = (count == '0) ? pat_pkg::S_RESP : pat_pkg::S_SRCH;
          end
          pat_pkg::OP_DUMP: begin
            state_next = (count == '0) ? pat_pkg::S_RESP : pat_pkg::S_DUMP_RD;
          end
          default: state_next = pat_pkg::S_IDLE;
        endcase
      end
      pat_pkg::S_SHUP: begin
        if (rptr == p) state_next = pat_pkg::S_SHUP_LAST;
      end
      pat_pkg::S_SHUP_LAST: state_next = pat_pkg::S_INS_WR;
      pat_pkg::S_INS_WR:    state_next = pat_pkg::S_RESP;
      pat_pkg::S_SHDN: begin
        if (rptr == last_idx) state_next = pat_pkg::S_SHDN_LAST;
      end
      pat_pkg::S_SHDN_LAST: state_next = pat_pkg::S_RESP;
      pat_pkg::S_SRCH: begin
        if (found || (cvalid && cmp_last)) state_next = pat_pkg::S_RESP;
      end
      pat_pkg::S_DUMP_RD: state_next = pat_pkg::S_DUMP_EM;
      pat_pkg::S_DUMP_EM: begin
        if (out_free) begin
          state_next = (rptr == last_idx) ? pat_pkg::S_IDLE : pat_pkg::S_DUMP_RD;
        end
      end
      pat_pkg::S_RESP: begin
        if (out_free) state_next = pat_pkg::S_IDLE;
      end
      default: state_next = pat_pkg::S_IDLE;
    endcase
  end

  // Outputs: request handshake, memory port and result word.
  always_comb begin
    req_ready     = state == pat_pkg::S_IDLE;
    ram_raddr     = rptr;
    ram_wr.we     = 1'b0;
    ram_wr.addr   = wptr;
    ram_wr.data   = ram_rdata;
    res_valid     = 1'b0;
    res.status    = st;
    res.index     = pat_pkg::OIDX_W'(idx);
    res.data      = '0;
    res.count     = pat_pkg::OCNT_W'(count);
    res.last      = 1'b1;
    unique case (state)
      pat_pkg::S_DECODE: begin
        if ((op == pat_pkg::OP_UPDATE) && (pos < cnt8)) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = pat_pkg::IDX_W'(pos);
          ram_wr.data = val;
        end
      end
      pat_pkg::S_SHUP, pat_pkg::S_SHDN:           ram_wr.we = wpend;
      pat_pkg::S_SHUP_LAST, pat_pkg::S_SHDN_LAST: ram_wr.we = 1'b1;
      pat_pkg::S_INS_WR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = p;
        ram_wr.data = val;
      end
      pat_pkg::S_DUMP_EM: begin
        res_valid  = out_free;
        res.status = pat_pkg::ST_OK;
        res.index  = pat_pkg::OIDX_W'(rptr);
        res.data   = ram_rdata;
        res.last   = rptr == last_idx;
      end
      pat_pkg::S_RESP: res_valid = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wpend  <= 1'b0;
      cvalid <= 1'b0;
    end else begin
      case (state)
        pat_pkg::S_IDLE: begin
          if (req_valid) begin
            op  <= req.opcode;
            val <= req.value;
            pos <= req.position;
          end
        end
        pat_pkg::S_DECODE: begin
          idx    <= '0;
          wpend  <= 1'b0;
          cvalid <= 1'b0;
          case (op) inside
            pat_pkg::OP_INS_END, pat_pkg::OP_INS_START, pat_pkg::OP_INS_POS: begin
              if (full)         st <= pat_pkg::ST_FULL;
              else if (ins_bad) st <= pat_pkg::ST_BAD_POS;
              else              st <= pat_pkg::ST_OK;
              p    <= pat_pkg::IDX_W'(ins_pos8);
              rptr <= last_idx;
            end
            pat_pkg::OP_DEL_END: begin
              if (count == '0) begin
                st <= pat_pkg::ST_EMPTY;
              end else begin
                st    <= pat_pkg::ST_OK;
                count <= count - 1'b1;
              end
            end
            pat_pkg::OP_DEL_START, pat_pkg::OP_DEL_POS: begin
              if (del_pos8 >= cnt8) begin
                st <= (op == pat_pkg::OP_DEL_START) ? pat_pkg::ST_EMPTY
                                                    : pat_pkg::ST_BAD_POS;
              end else begin
                st <= pat_pkg::ST_OK;
                if (del_pos8 == cnt8 - 1'b1) count <= count - 1'b1;
              end
              rptr <= pat_pkg::IDX_W'(del_pos8) + 1'b1;
            end
            pat_pkg::OP_SEARCH: begin
              st   <= (count == '0) ? pat_pkg::ST_NOT_FOUND : pat_pkg::ST_OK;
              rptr <= '0;
            end
            pat_pkg::OP_UPDATE: begin
              st <= (pos >= cnt8) ? pat_pkg::ST_BAD_POS : pat_pkg::ST_OK;
            end
            pat_pkg::OP_DUMP: begin
              st   <= (count == '0) ? pat_pkg::ST_EMPTY : pat_pkg::ST_OK;
              rptr <= '0;
            end
            default: ;
          endcase
        end
        // Shift up: read entry rptr, write it one place higher next cycle.
        pat_pkg::S_SHUP: begin
          wpend <= 1'b1;
          wptr  <= rptr + 1'b1;
          rptr  <= rptr - 1'b1;
        end
        pat_pkg::S_INS_WR:    count <= count + 1'b1;
        pat_pkg::S_SHDN: begin
          wpend <= 1'b1;
          wptr  <= rptr - 1'b1;
          rptr  <= rptr + 1'b1;
        end
        pat_pkg::S_SHDN_LAST: count <= count - 1'b1;
        // Search compares the word read in the previous cycle.
        pat_pkg::S_SRCH: begin
          cvalid <= 1'b1;
          cptr   <= rptr;
          rptr   <= rptr + 1'b1;
          if (found)                  idx <= cptr;
          else if (cvalid && cmp_last) st <= pat_pkg::ST_NOT_FOUND;
        end
        pat_pkg::S_DUMP_EM: begin
          if (out_free && (rptr != last_idx)) rptr <= rptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pat_pkg::CNT_W'(pat_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_res_when_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result issued while output stage is occupied");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> (pat_pkg::POS_W'(ram_wr.addr) <= cnt8))
    else $error("memory write beyond the end of the list");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + 1'b1) || (count == $past(count) - 1'b1)))
    else $error("entry count moved by more than one");
`endif

endmodule

/* design/positional_array_table.sv */
// ----------------------------------------------------------------------------
// positional_array_table
// Packed list of signed 32-bit words with insert, delete, search, update and
// dump operations, held in a synchronous entry memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the opcode, s_tdata the
// value and position. Results leave on the m_ stream: m_tuser carries the
// status, m_tdata index, data and count, m_tlast marks the final word of a
// request. Every request gives one result word, except a dump, which gives
// one word per entry (one if empty), and an undefined opcode, which gives none.
// One request is handled at a time; s_tready is high only while idle.
// Shifts, searches and dumps walk the entry memory one word at a time through
// its single read port.
// An output register sits between the sequencer and m_; while the receiver
// stalls, the sequencer holds its next result and waits.
// capacity_limit is written through the APB port at address 0 while idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset empties the list and sets capacity_limit to 16; the memory contents
// need no clearing, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value [31:0], position [39:32]
  input  logic [3:0]  s_tuser,   // opcode [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // index [3:0], data [35:4], count [40:36], zero
  output logic [2:0]  m_tuser,   // status [2:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pat_pkg::CAP_W-1:0]         cap_limit;
  pat_pkg::request_t                 req;
  pat_pkg::result_t                  res, out_res;
  logic                              res_valid, out_free;
  pat_pkg::ram_wr_t                  ram_wr;
  logic [pat_pkg::IDX_W-1:0]         ram_raddr;
  logic signed [pat_pkg::WORD_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pat_pkg::REG_CAPACITY) ? 32'(cap_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= pat_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pat_pkg::REG_CAPACITY)) begin
      cap_limit <= pwdata[pat_pkg::CAP_W-1:0];
    end
  end

  assign req.opcode   = s_tuser;
  assign req.value    = s_tdata[31:0];
  assign req.position = s_tdata[39:32];

  pat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .cap_limit (cap_limit),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pat_ram #(
    .WIDTH (pat_pkg::WORD_W),
    .DEPTH (pat_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register; it can take a new word in the cycle the old one leaves.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'b0, out_res.count, out_res.data, out_res.index};
  assign m_tuser = out_res.status;
  assign m_tlast = out_res.last;

endmodule

/* dv/tb_positional_array_table.sv */
// ----------------------------------------------------------------------------
// tb_positional_array_table
// Self-checking bench for the positional array table. A queue-fed driver
// offers request words, a shadow copy of the list predicts every result word,
// and a monitor compares the result stream field by field. The capacity
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_positional_array_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 24;
  localparam int IDLE_LIMIT  = 4 * (HOLD_CYCLES + 100);
  localparam int MAX_PRINTS  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // value [31:0], position [39:32]
  logic [3:0]  s_tuser = '0;    // opcode [3:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // index [3:0], data [35:4], count [40:36], zero
  logic [2:0]  m_tuser;         // status [2:0]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  positional_array_table dut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the list and of the capacity register.
  logic signed [pat_pkg::WORD_W-1:0] shadow_list [pat_pkg::DEPTH];
  int                                shadow_count = 0;
  logic [pat_pkg::CAP_W-1:0]         shadow_cap = pat_pkg::CAP_RESET;

  pat_pkg::result_t  expected_q [$];
  pat_pkg::request_t word_q [$];
  pat_pkg::request_t cur_req;

  int n_queued = 0;
  int n_acc = 0;
  int n_words_out = 0;
  int n_cfg = 0;
  int n_err = 0;

  pat_pkg::opcode_t ins_ops [3] =
    '{pat_pkg::OP_INS_END, pat_pkg::OP_INS_START, pat_pkg::OP_INS_POS};
  pat_pkg::opcode_t del_ops [3] =
    '{pat_pkg::OP_DEL_END, pat_pkg::OP_DEL_START, pat_pkg::OP_DEL_POS};
  logic signed [pat_pkg::WORD_W-1:0] value_pool [6] =
    '{32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd5, 32'sd6};

  task automatic report_mismatch(string msg);
    n_err++;
    if (n_err <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic void queue_result(pat_pkg::status_t st,
                                       logic [pat_pkg::OIDX_W-1:0] idx,
                                       logic signed [pat_pkg::WORD_W-1:0] d,
                                       logic l);
    pat_pkg::result_t r;
    r.status = st;
    r.index  = idx;
    r.data   = d;
    r.count  = pat_pkg::OCNT_W'(shadow_count);
    r.last   = l;
    expected_q.push_back(r);
  endfunction

  function automatic pat_pkg::status_t list_insert(int pos,
                                                   logic signed [pat_pkg::WORD_W-1:0] v);
    int lim;
    lim = (shadow_cap > pat_pkg::DEPTH) ? pat_pkg::DEPTH : int'(shadow_cap);
    if (shadow_count >= lim) return pat_pkg::ST_FULL;
    if (pos > shadow_count) return pat_pkg::ST_BAD_POS;
    for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = v;
    shadow_count++;
    return pat_pkg::ST_OK;
  endfunction

  function automatic pat_pkg::status_t list_delete(int pos);
    if (pos >= shadow_count) return pat_pkg::ST_BAD_POS;
    for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return pat_pkg::ST_OK;
  endfunction

  // Applies one accepted request to the shadow list and queues its results.
  function automatic void predict_results(pat_pkg::request_t r);
    pat_pkg::status_t           st;
    logic [pat_pkg::OIDX_W-1:0] idx;
    int                         pos;
    st  = pat_pkg::ST_OK;
    idx = '0;
    pos = int'(r.position);
    case (r.opcode)
      pat_pkg::OP_INS_END:   st = list_insert(shadow_count, r.value);
      pat_pkg::OP_INS_START: st = list_insert(0, r.value);
      pat_pkg::OP_INS_POS:   st = list_insert(pos, r.value);
      pat_pkg::OP_DEL_END: begin
        if (shadow_count == 0) st = pat_pkg::ST_EMPTY;
        else shadow_count--;
      end
      pat_pkg::OP_DEL_START: begin
        st = (shadow_count == 0) ? pat_pkg::ST_EMPTY : list_delete(0);
      end
      pat_pkg::OP_DEL_POS:   st = list_delete(pos);
      pat_pkg::OP_SEARCH: begin
        st = pat_pkg::ST_NOT_FOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (st == pat_pkg::ST_NOT_FOUND && shadow_list[i] == r.value) begin
            st  = pat_pkg::ST_OK;
            idx = pat_pkg::OIDX_W'(i);
          end
        end
      end
      pat_pkg::OP_UPDATE: begin
        if (pos >= shadow_count) st = pat_pkg::ST_BAD_POS;
        else shadow_list[pos] = r.value;
      end
      pat_pkg::OP_DUMP: begin
        if (shadow_count == 0) queue_result(pat_pkg::ST_EMPTY, '0, '0, 1'b1);
        else begin
          for (int i = 0; i < shadow_count; i++)
            queue_result(pat_pkg::ST_OK, pat_pkg::OIDX_W'(i), shadow_list[i],
                         i + 1 == shadow_count);
        end
        return;
      end
      default: return;
    endcase
    queue_result(st, idx, '0, 1'b1);
  endfunction

  // Request driver: one word in flight, a random gap after each accepted word.
  int src_wait = 0;
  bit src_burst = 1'b0;

  always @(posedge clk) begin
    logic give;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      give = 1'b0;
      if (s_tvalid && s_tready) begin
        predict_results(cur_req);
        n_acc++;
        if ($urandom_range(0, 19) == 0) src_burst = !src_burst;
        src_wait = src_burst ? 0 : $urandom_range(0, 16);
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait > 0) src_wait--;
        else if (word_q.size() > 0) begin
          cur_req = word_q.pop_front();
          give = 1'b1;
        end
      end else begin
        give = 1'b1;
      end
      s_tvalid <= give;
      if (give) begin
        s_tdata <= {cur_req.position, cur_req.value};
        s_tuser <= cur_req.opcode;
      end
    end
  end

  // One long receiver stall once enough requests have gone in, so that the
  // output register fills and the input side backs up.
  int hold_left = 0;
  int hold_seen = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else begin
      if (s_tvalid && s_tready) hold_seen <= hold_seen + 1;
      if (!hold_done && hold_seen >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Result monitor.
  int sink_wait = 0;
  bit sink_burst = 1'b0;

  always @(posedge clk) begin
    pat_pkg::result_t e;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_words_out++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word status=%0d data=%0h",
                                    m_tuser, m_tdata[35:4]));
        end else begin
          e = expected_q.pop_front();
          if (m_tuser != e.status || m_tdata[3:0] != e.index ||
              m_tdata[35:4] != e.data || m_tdata[40:36] != e.count ||
              m_tlast != e.last)
            report_mismatch($sformatf(
              "word %0d got st=%0d idx=%0d data=%0h cnt=%0d last=%0b, %s",
              n_words_out, m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[40:36],
              m_tlast,
              $sformatf("exp st=%0d idx=%0d data=%0h cnt=%0d last=%0b",
                        e.status, e.index, e.data, e.count, e.last)));
        end
        if ($urandom_range(0, 19) == 0) sink_burst = !sink_burst;
        sink_wait = sink_burst ? 0 : $urandom_range(0, 16);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      m_tready <= (sink_wait == 0) && (hold_left == 0);
    end
  end

  // Watchdog on cycles in which nothing moves.
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("tb_positional_array_table NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(logic [pat_pkg::OP_W-1:0] op,
                      logic signed [pat_pkg::WORD_W-1:0] v, int p);
    pat_pkg::request_t r;
    r.opcode   = op;
    r.value    = v;
    r.position = pat_pkg::POS_W'(p);
    word_q.push_back(r);
    n_queued++;
  endtask

  // Waits until every queued word is in and every result is out, then lets
  // an ignored opcode finish in the block.
  task automatic drain();
    @(negedge clk);
    while (n_acc != n_queued || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(logic [pat_pkg::CAP_W-1:0] c);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {pat_pkg::REG_CAPACITY, 2'b00};
    pwdata  <= {27'($urandom_range(0, 32'h07ff_ffff)), c};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_cap = c;
    n_cfg++;
    // Read it back.
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[pat_pkg::CAP_W-1:0] != c)
      report_mismatch($sformatf("capacity read back %0d, wrote %0d",
                                prdata[pat_pkg::CAP_W-1:0], c));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic pat_pkg::request_t random_word(int grow);
    pat_pkg::request_t r;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < grow) r.opcode = ins_ops[$urandom_range(0, 2)];
    else if (pick < 80) r.opcode = del_ops[$urandom_range(0, 2)];
    else if (pick < 88) r.opcode = pat_pkg::OP_SEARCH;
    else if (pick < 94) r.opcode = pat_pkg::OP_UPDATE;
    else if (pick < 98) r.opcode = pat_pkg::OP_DUMP;
    else r.opcode = pat_pkg::OP_W'($urandom_range(9, 15));
    // Mostly a small pool of values so that searches hit.
    if ($urandom_range(0, 2) == 0) r.value = $urandom();
    else r.value = value_pool[$urandom_range(0, 5)];
    if ($urandom_range(0, 99) < 85) begin
      r.position = pat_pkg::POS_W'($urandom_range(0, pat_pkg::DEPTH + 1));
    end else begin
      r.position = pat_pkg::POS_W'($urandom_range(0, 255));
    end
    return r;
  endfunction

  logic [pat_pkg::CAP_W-1:0] phase_caps [8] =
    '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd2, 5'd8, 5'd16};

  initial begin
    pat_pkg::request_t r;
    int                real_items;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty list corner cases, then field extremes, at the reset capacity.
    send(pat_pkg::OP_DUMP, 0, 0);
    send(pat_pkg::OP_DEL_END, 0, 0);
    send(pat_pkg::OP_DEL_START, 0, 0);
    send(pat_pkg::OP_DEL_POS, 0, 0);
    send(pat_pkg::OP_UPDATE, 1, 0);
    send(pat_pkg::OP_SEARCH, 0, 0);
    send(pat_pkg::OP_INS_POS, 7, 1);
    send(pat_pkg::OP_INS_END, 32'sh7fffffff, 0);
    send(pat_pkg::OP_INS_START, 32'sh80000000, 255);
    send(pat_pkg::OP_INS_POS, 0, 1);
    send(pat_pkg::OP_INS_POS, 9, 255);
    send(pat_pkg::OP_INS_END, -1, 0);
    send(pat_pkg::OP_SEARCH, -1, 0);
    send(pat_pkg::OP_SEARCH, 12345, 0);
    send(pat_pkg::OP_UPDATE, 32'sh55555555, 0);
    send(pat_pkg::OP_UPDATE, 3, 255);
    send(pat_pkg::OP_DEL_POS, 0, 1);
    send(pat_pkg::OP_DEL_POS, 0, 255);
    send(4'd9, -1, 255);
    send(4'd15, 0, 0);
    send(pat_pkg::OP_DUMP, 0, 0);
    drain();

    // Capacity above the depth saturates: fill the list completely.
    write_capacity(5'd31);
    for (int i = 0; i < pat_pkg::DEPTH + 1; i++) send(pat_pkg::OP_INS_END, $urandom(), 0);
    send(pat_pkg::OP_INS_POS, 1, 200);
    send(pat_pkg::OP_DUMP, 0, 0);
    drain();

    // Capacity below the count keeps the entries but refuses inserts.
    write_capacity(5'd3);
    send(pat_pkg::OP_INS_START, 4, 0);
    send(pat_pkg::OP_DEL_START, 0, 0);
    send(pat_pkg::OP_INS_END, 4, 0);
    send(pat_pkg::OP_DUMP, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) write_capacity(phase_caps[ph]);
      else write_capacity(5'($urandom_range(0, 31)));
      real_items = 0;
      while (real_items < 20) begin
        r = random_word((ph % 2 == 0) ? 60 : 35);
        if (r.opcode <= pat_pkg::OP_DUMP) real_items++;
        send(r.opcode, r.value, int'(r.position));
      end
      drain();
    end

    $display("Ran %0d request words and %0d result words over %0d capacity settings.",
             n_acc, n_words_out, n_cfg + 1);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("tb_positional_array_table OK");
    end else begin
      $display("tb_positional_array_table NOT OK");
    end
    $finish;
  end

endmodule
